// File: hw/rtl/kcht_pkg.sv
package kcht_pkg;

   localparam int TABLE_DEPTH = 65536;
   localparam int COUNT_BITS  = 16;
   localparam int KMER_BITS   = 64;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int SIZE_BITS   = ADDR_BITS + 1;
   localparam int OUT_COUNT_BITS = 16;

   localparam logic [1:0] REQ_COUNT = 2'd0;
   localparam logic [1:0] REQ_EXIST = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [1:0] CSR_KMER_MASK  = 2'd0;
   localparam logic [1:0] CSR_TABLE_SIZE = 2'd1;
   localparam logic [1:0] CSR_MIN_COUNT  = 2'd2;
   localparam logic [1:0] CSR_MAX_COUNT  = 2'd3;

   typedef struct packed {
      logic                  valid;
      logic [COUNT_BITS-1:0] count;
      logic [KMER_BITS-1:0]  kmer;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic                      hit;
      logic                      inserted;
      logic [ADDR_BITS-1:0]      slot;
      logic [KMER_BITS-1:0]      kmer;
      logic [OUT_COUNT_BITS-1:0] count;
      logic                      filt;
      logic                      load;
      logic                      err;
   } res_type;

endpackage

// File: hw/rtl/kcht_ram.sv
module kcht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: hw/rtl/kcht_mod.sv
module kcht_mod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [kcht_pkg::KMER_BITS-1:0] dividend,
   input  logic [kcht_pkg::SIZE_BITS-1:0] divisor,
   output logic                           done,
   output logic [kcht_pkg::SIZE_BITS-1:0] remainder
);
   import kcht_pkg::*;

   localparam int CNT_BITS = $clog2(KMER_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [KMER_BITS-1:0] dvd_ff, dvd_in;
   logic [SIZE_BITS-1:0] rem_ff, rem_in;
   logic [SIZE_BITS-1:0] dsr_ff, dsr_in;
   logic [SIZE_BITS:0]   shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, dvd_ff[KMER_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = SIZE_BITS'(shifted - {1'b0, dsr_ff});
         end else begin
            rem_in = shifted[SIZE_BITS-1:0];
         end
         dvd_in = {dvd_ff[KMER_BITS-2:0], 1'b0};
         cnt_in = CNT_BITS'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_BITS'(KMER_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: hw/rtl/kmer_count_hash_table.sv
// K-mer counter held in an open-addressed table probed by double hashing.
// The request channel (req_valid/req_ready) carries one transaction per
// k-mer: count or insert, count an existing k-mer only, or read one slot.
// The response channel (rsp_valid/rsp_ready) returns exactly one transaction
// per request, in order. Configuration registers are written through the
// csr_ port at any time; they must only change while the block is idle.
// A count request first runs two parallel bit-serial modulo units (home
// slot and probe step), then for each probe reads the table memory and
// checks the slot, and then posts the response. A read request reads and
// checks its one slot, then posts the response. One request is in flight at
// a time; req_ready rises in the cycle after a response has been posted,
// even if that response is still waiting for the receiver.
// After reset the block sweeps every slot of the table memory once, one slot
// per cycle, and does not accept requests during that pass.
// If the receiver stalls, a finished result waits in its internal stage
// and the block holds off further requests until the response register frees.
module kmer_count_hash_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic [kcht_pkg::KMER_BITS-1:0]      req_kmer_value,
   input  logic [kcht_pkg::ADDR_BITS-1:0]      req_slot_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic                                rsp_inserted,
   output logic [kcht_pkg::ADDR_BITS-1:0]      rsp_slot,
   output logic [kcht_pkg::KMER_BITS-1:0]      rsp_stored_kmer,
   output logic [kcht_pkg::OUT_COUNT_BITS-1:0] rsp_entry_count,
   output logic                                rsp_passes_filter,
   output logic                                rsp_load_exceeded,
   output logic                                rsp_table_full_error,
   input  logic                                csr_wr_en,
   input  logic [1:0]                          csr_index,
   input  logic [kcht_pkg::KMER_BITS-1:0]      csr_wdata
);
   import kcht_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_RD     = 3'd3;
   localparam logic [2:0] ST_CHK    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [KMER_BITS-1:0]  mask_ff;
   logic [SIZE_BITS-1:0]  tsize_ff;
   logic [COUNT_BITS-1:0] min_ff;
   logic [COUNT_BITS-1:0] max_ff;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           rtype_ff, rtype_in;
   logic [KMER_BITS-1:0] kmer_ff, kmer_in;
   logic [ADDR_BITS-1:0] key_ff, key_in;
   logic [ADDR_BITS-1:0] home_ff, home_in;
   logic [SIZE_BITS-1:0] step_ff, step_in;
   logic [SIZE_BITS-1:0] pcnt_ff, pcnt_in;
   logic [SIZE_BITS-1:0] occ_ff, occ_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   res_type              res_ff, res_in;
   res_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [SIZE_BITS-1:0]  size;
   logic [SIZE_BITS-1:0]  next_sum;
   logic [SIZE_BITS-1:0]  pcnt_next;
   logic [COUNT_BITS-1:0] new_count;
   logic                  mod_start;
   logic                  home_done;
   logic                  step_done;
   logic [SIZE_BITS-1:0]  rem_home;
   logic [SIZE_BITS-1:0]  rem_step;
   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   entry_type             ram_wdata;
   entry_type             ram_rdata;

   always_comb begin
      size = tsize_ff;
      if (tsize_ff < SIZE_BITS'(2)) begin
         size = SIZE_BITS'(2);
      end else if (tsize_ff > SIZE_BITS'(TABLE_DEPTH)) begin
         size = SIZE_BITS'(TABLE_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '1;
         tsize_ff <= SIZE_BITS'(65521);
         min_ff   <= COUNT_BITS'(2);
         max_ff   <= COUNT_BITS'(65535);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KMER_MASK:  mask_ff  <= csr_wdata;
            CSR_TABLE_SIZE: tsize_ff <= csr_wdata[SIZE_BITS-1:0];
            CSR_MIN_COUNT:  min_ff   <= csr_wdata[COUNT_BITS-1:0];
            CSR_MAX_COUNT:  max_ff   <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   kcht_mod u_mod_home (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_kmer_value & mask_ff),
      .divisor   (size),
      .done      (home_done),
      .remainder (rem_home)
   );

   kcht_mod u_mod_step (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_kmer_value & mask_ff),
      .divisor   (SIZE_BITS'(size - 1'b1)),
      .done      (step_done),
      .remainder (rem_step)
   );

   kcht_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (key_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      rtype_in     = rtype_ff;
      kmer_in      = kmer_ff;
      key_in       = key_ff;
      home_in      = home_ff;
      step_in      = step_ff;
      pcnt_in      = pcnt_ff;
      occ_in       = occ_ff;
      clr_in       = clr_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mod_start    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = key_ff;
      ram_wdata    = '0;
      next_sum     = SIZE_BITS'({1'b0, key_ff} + step_ff);
      pcnt_next    = SIZE_BITS'(pcnt_ff + 1'b1);
      new_count    = (ram_rdata.count == '1) ? ram_rdata.count
                                              : COUNT_BITS'(ram_rdata.count + 1'b1);
      if (next_sum >= size) begin
         next_sum = SIZE_BITS'(next_sum - size);
      end
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = ADDR_BITS'(clr_ff + 1'b1);
            if (clr_ff == ADDR_BITS'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               rtype_in = req_type;
               kmer_in  = req_kmer_value & mask_ff;
               key_in   = req_slot_index;
               res_in   = '0;
               if (req_type == REQ_READ) begin
                  state_in = ST_RD;
               end else if (req_type inside {REQ_COUNT, REQ_EXIST}) begin
                  mod_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DIV: begin
            if (home_done && step_done) begin
               home_in  = rem_home[ADDR_BITS-1:0];
               key_in   = rem_home[ADDR_BITS-1:0];
               step_in  = SIZE_BITS'(rem_step + 1'b1);
               pcnt_in  = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            res_in.slot = key_ff;
            state_in    = ST_FINISH;
            if (rtype_ff == REQ_READ) begin
               if (ram_rdata.valid) begin
                  res_in.hit   = 1'b1;
                  res_in.kmer  = ram_rdata.kmer;
                  res_in.count = OUT_COUNT_BITS'(ram_rdata.count);
                  res_in.filt  = (ram_rdata.count >= min_ff) && (ram_rdata.count <= max_ff);
               end
            end else if (!ram_rdata.valid) begin
               if (rtype_ff == REQ_COUNT) begin
                  ram_we          = 1'b1;
                  ram_wdata.valid = 1'b1;
                  ram_wdata.count = COUNT_BITS'(1);
                  ram_wdata.kmer  = kmer_ff;
                  occ_in          = SIZE_BITS'(occ_ff + 1'b1);
                  res_in.inserted = 1'b1;
                  res_in.kmer     = kmer_ff;
                  res_in.count    = OUT_COUNT_BITS'(1);
                  res_in.filt     = (COUNT_BITS'(1) >= min_ff) && (COUNT_BITS'(1) <= max_ff);
               end
            end else if ((ram_rdata.kmer & mask_ff) == kmer_ff) begin
               ram_we          = 1'b1;
               ram_wdata.valid = 1'b1;
               ram_wdata.count = new_count;
               ram_wdata.kmer  = ram_rdata.kmer;
               res_in.hit      = 1'b1;
               res_in.kmer     = ram_rdata.kmer;
               res_in.count    = OUT_COUNT_BITS'(new_count);
               res_in.filt     = (new_count >= min_ff) && (new_count <= max_ff);
            end else if (pcnt_next == size) begin
               res_in.slot = home_ff;
               res_in.err  = 1'b1;
            end else begin
               pcnt_in  = pcnt_next;
               key_in   = next_sum[ADDR_BITS-1:0];
               state_in = ST_RD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_in.load  = occ_ff > {1'b0, size[SIZE_BITS-1:1]};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rtype_ff <= rtype_in;
      kmer_ff  <= kmer_in;
      key_ff   <= key_in;
      home_ff  <= home_in;
      step_ff  <= step_in;
      pcnt_ff  <= pcnt_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_ff.hit;
   assign rsp_inserted         = rsp_ff.inserted;
   assign rsp_slot             = rsp_ff.slot;
   assign rsp_stored_kmer      = rsp_ff.kmer;
   assign rsp_entry_count      = rsp_ff.count;
   assign rsp_passes_filter    = rsp_ff.filt;
   assign rsp_load_exceeded    = rsp_ff.load;
   assign rsp_table_full_error = rsp_ff.err;

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= SIZE_BITS'(TABLE_DEPTH))
      else $error("occupancy counter exceeds table depth");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inserted |-> rsp_entry_count == OUT_COUNT_BITS'(1) && !rsp_hit)
      else $error("inserted entry must report count one and no hit");

   a_full_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full_error |-> !rsp_hit && !rsp_inserted)
      else $error("full-table error reported with a match or insert");

   a_write_when: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_CHK))
      else $error("table write outside clearing or check");
`endif

endmodule
